### rtl/mtst_pkg.sv
package mtst_pkg;

  // number of task slots in the cell row
  localparam int unsigned NUM_TASKS = 16;
  localparam int unsigned TASK_W    = 4;
  localparam int unsigned TIME_W    = 32;

  // request limits
  localparam logic [TIME_W-1:0] SEC_REQ_LIMIT  = 32'd42949672;   // 0xffffffff / 100
  localparam logic [TIME_W-1:0] US_REQ_LIMIT   = 32'hFFFF_D8F1;  // 0xffffffff - 9998
  localparam logic [TIME_W-1:0] DEBUG_US_LIMIT = 32'd1000000;

  // tick conversion
  localparam logic [6:0]        TICKS_PER_SEC  = 7'd100;
  localparam logic [TIME_W-1:0] US_ROUND_UP    = 32'd9999;
  // x / 10000 == (x * US_RECIP) >> US_SHIFT for every 32-bit x
  localparam logic [TIME_W-1:0] US_RECIP       = 32'hD1B7_1759;
  localparam int unsigned       US_SHIFT       = 45;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SLEEP_SEC = 2'd1,
    OP_SLEEP_US  = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  // scan word handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [TIME_W-1:0] best_dist;
    logic [TIME_W-1:0] best_dl;
  } scan_word_t;

endpackage

### rtl/mtst_cell.sv
module mtst_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mtst_pkg::TIME_W-1:0]      tick_count,
  input  logic                             wr_en,
  input  logic [mtst_pkg::TIME_W-1:0]      wr_deadline,
  input  mtst_pkg::scan_word_t             word_in,
  output mtst_pkg::scan_word_t             word_out,
  output logic                             wake
);

  logic                        asleep;
  logic [mtst_pkg::TIME_W-1:0] deadline;
  logic [mtst_pkg::TIME_W-1:0] span;
  logic                        due;
  logic                        closer;

  assign span   = deadline - tick_count;
  assign due    = asleep && (deadline == tick_count);
  assign closer = asleep && !due && (!word_in.found || (span < word_in.best_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      asleep       <= 1'b0;
      wake         <= 1'b0;
      word_out.vld <= 1'b0;
    end else begin
      wake         <= word_in.vld && due;
      word_out.vld <= word_in.vld;
      if (wr_en) begin
        asleep <= 1'b1;
      end else if (word_in.vld && due) begin
        asleep <= 1'b0;
      end
    end
    if (wr_en) begin
      deadline <= wr_deadline;
    end
    // payload of the scan word
    if (closer) begin
      word_out.found     <= 1'b1;
      word_out.best_dist <= span;
      word_out.best_dl   <= deadline;
    end else begin
      word_out.found     <= word_in.found;
      word_out.best_dist <= word_in.best_dist;
      word_out.best_dl   <= word_in.best_dl;
    end
  end

endmodule

### rtl/multi_task_sleep_timer_core.sv
// multi-task sleep timer
//
// command channel: drive opcode, task_id and sleep_amount with start high; the
// word is taken at a clock edge where start is high and busy is low. busy stays
// high until the result is out.
// result channel: done is high for exactly one cycle with wake_mask, status and
// counting; the receiver cannot stall, so the result must be taken that cycle.
// config channel: cfg_data is written into debug_range_check at an edge where
// cfg_valid and cfg_ready are high; cfg_ready is always high and writes are
// only expected while the block is idle.
//
// path to done: a tick that reaches no deadline, opcode 3 and a rejected
// sleep request finish from ST_EVAL; an accepted sleep request passes
// through ST_EVAL and ST_APPLY; a tick that hits the nearest deadline goes
// to ST_SCAN and walks a scan word down the row of task cells, one cell a cycle.
// a new command can be accepted in the cycle done is high.
//
// reset (rst, synchronous) stops the counter, clears every task's sleep flag
// and the debug check, and leaves the block idle with no result pending.
module multi_task_sleep_timer_core (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [mtst_pkg::TASK_W-1:0]   task_id,
  input  logic [mtst_pkg::TIME_W-1:0]   sleep_amount,
  // result channel
  output logic                          done,
  output logic [mtst_pkg::NUM_TASKS-1:0] wake_mask,
  output logic                          status,
  output logic                          counting,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_SCAN
  } state_t;

  localparam int unsigned N  = mtst_pkg::NUM_TASKS;
  localparam int unsigned TW = mtst_pkg::TIME_W;

  state_t                       state;
  logic                         debug_range_check;
  logic [TW-1:0]                tick_count;
  logic                         running;
  logic [TW-1:0]                nearest_deadline;

  // latched command word
  mtst_pkg::opcode_t            opcode_q;
  logic [mtst_pkg::TASK_W-1:0]  task_q;
  logic [TW-1:0]                amount_q;

  // tick conversion product
  logic [2*TW-1:0]              prod;
  logic                         inject;
  logic [N-1:0]                 wake_acc;

  // per-cell wiring
  mtst_pkg::scan_word_t         word [N+1];
  logic [N-1:0]                 wake_vec;
  logic [N-1:0]                 wr_sel;

  // combinational helpers
  logic                         task_bad;
  logic                         sec_bad;
  logic                         us_bad;
  logic [TW-1:0]                tick_inc;
  logic [TW-1:0]                us_sum;
  logic [TW-1:0]                ticks_raw;
  logic [TW-1:0]                ticks;
  logic [TW-1:0]                new_deadline;
  logic                         accept;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // range checks on the latched request
  assign task_bad = (32'(task_q) >= 32'(N));
  assign sec_bad  = (amount_q >= mtst_pkg::SEC_REQ_LIMIT);
  assign us_bad   = (debug_range_check && (amount_q >= mtst_pkg::DEBUG_US_LIMIT))
                    || (amount_q >= mtst_pkg::US_REQ_LIMIT);

  assign tick_inc = tick_count + 32'd1;
  assign us_sum   = amount_q + mtst_pkg::US_ROUND_UP;

  // seconds take the low word, microseconds the scaled reciprocal product
  assign ticks_raw = (opcode_q == mtst_pkg::OP_SLEEP_SEC) ? prod[TW-1:0]
                     : TW'(prod[2*TW-1:mtst_pkg::US_SHIFT]);
  // zero ticks waits one tick rather than a whole counter wrap
  assign ticks        = (ticks_raw == '0) ? 32'd1 : ticks_raw;
  assign new_deadline = tick_count + ticks;

  // scan word enters the row at cell 0
  assign word[0].vld       = inject;
  assign word[0].found     = 1'b0;
  assign word[0].best_dist = '0;
  assign word[0].best_dl   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign wr_sel[i] = (state == ST_APPLY) && (32'(task_q) == i);
    mtst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .tick_count  (tick_count),
      .wr_en       (wr_sel[i]),
      .wr_deadline (new_deadline),
      .word_in     (word[i]),
      .word_out    (word[i+1]),
      .wake        (wake_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      debug_range_check <= 1'b0;
      tick_count        <= '0;
      running           <= 1'b0;
      nearest_deadline  <= '0;
      inject            <= 1'b0;
      done              <= 1'b0;
    end else begin
      done   <= 1'b0;
      inject <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        debug_range_check <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          unique case (opcode_q)
            mtst_pkg::OP_TICK: begin
              if (!running) begin
                state     <= ST_IDLE;
                done      <= 1'b1;
                wake_mask <= '0;
                status    <= 1'b0;
                counting  <= 1'b0;
              end else if (nearest_deadline == tick_inc) begin
                // deadline reached, walk the cells
                tick_count <= tick_inc;
                inject     <= 1'b1;
                wake_acc   <= '0;
                state      <= ST_SCAN;
              end else begin
                tick_count <= tick_inc;
                state      <= ST_IDLE;
                done       <= 1'b1;
                wake_mask  <= '0;
                status     <= 1'b0;
                counting   <= 1'b1;
              end
            end
            mtst_pkg::OP_SLEEP_SEC, mtst_pkg::OP_SLEEP_US: begin
              if (task_bad || ((opcode_q == mtst_pkg::OP_SLEEP_SEC) ? sec_bad : us_bad)) begin
                state     <= ST_IDLE;
                done      <= 1'b1;
                wake_mask <= '0;
                status    <= 1'b1;
                counting  <= running;
              end else begin
                state <= ST_APPLY;
              end
            end
            mtst_pkg::OP_NONE: begin
              state     <= ST_IDLE;
              done      <= 1'b1;
              wake_mask <= '0;
              status    <= 1'b0;
              counting  <= running;
            end
          endcase
        end
        ST_APPLY: begin
          // only pull the nearest deadline in, a stale one is fixed by the next scan
          if (!running || ((nearest_deadline - tick_count) > ticks)) begin
            nearest_deadline <= new_deadline;
          end
          running   <= 1'b1;
          state     <= ST_IDLE;
          done      <= 1'b1;
          wake_mask <= '0;
          status    <= 1'b0;
          counting  <= 1'b1;
        end
        ST_SCAN: begin
          wake_acc <= wake_acc | wake_vec;
          if (word[N].vld) begin
            if (word[N].found) begin
              nearest_deadline <= word[N].best_dl;
            end
            running   <= word[N].found;
            state     <= ST_IDLE;
            done      <= 1'b1;
            wake_mask <= wake_acc | wake_vec;
            status    <= 1'b0;
            counting  <= word[N].found;
          end
        end
      endcase
    end
    // command word and conversion product carry no reset
    if (accept) begin
      opcode_q <= mtst_pkg::opcode_t'(opcode);
      task_q   <= task_id;
      amount_q <= sleep_amount;
    end
    if (state == ST_EVAL) begin
      if (opcode_q == mtst_pkg::OP_SLEEP_SEC) begin
        prod <= {{TW{1'b0}}, TW'(amount_q * mtst_pkg::TICKS_PER_SEC)};
      end else begin
        prod <= {{TW{1'b0}}, us_sum} * {{TW{1'b0}}, mtst_pkg::US_RECIP};
      end
    end
  end

endmodule

### rtl/mtst_checker.sv
module mtst_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [mtst_pkg::NUM_TASKS-1:0] wake_mask,
  input logic                           status
);

  // one command in flight: a taken word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but busy not raised");

  // results never come in adjacent cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // a rejected request never wakes anyone
  a_reject_no_wake: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (wake_mask == '0))
    else $error("wake bits on a rejected request");

  // after reset the block is idle with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // wake bits only come with an accepted status
  a_wake_needs_count: assert property (@(posedge clk) disable iff (rst)
    (done && (wake_mask != '0)) |-> !status)
    else $error("wake bits with reject status");

endmodule

bind multi_task_sleep_timer_core mtst_checker u_mtst_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .wake_mask (wake_mask),
  .status    (status)
);

### sim/multi_task_sleep_timer_core_tb.sv
`timescale 1ns / 100ps

module multi_task_sleep_timer_core_tb;
  import mtst_pkg::*;

  // watchdog: cycles in a row with no word moving on any channel
  localparam int STALL_LIMIT = 400;

  typedef struct packed {
    logic [NUM_TASKS-1:0] wake_mask;
    logic                 status;
    logic                 counting;
  } timer_result_t;

  // scoreboard: keeps its own copy of the timer state and predicts the
  // result of every command word the block takes
  class sleep_timer_scoreboard;
    bit                debug_check;
    bit [TIME_W-1:0]   tick_now;
    bit                running;
    bit [TIME_W-1:0]   nearest;
    bit [TIME_W-1:0]   deadline [NUM_TASKS];
    bit                asleep [NUM_TASKS];
    timer_result_t     expected_q [$];
    int                errors;

    function void set_debug_check(bit value);
      debug_check = value;
    endfunction

    // put a task to sleep for a number of ticks; zero counts as one tick
    function void arm_task(int unsigned t, bit [TIME_W-1:0] ticks);
      if (ticks == 0)
        ticks = 1;
      if (running) begin
        // only pull the nearest deadline in, a stale one is fixed by the next scan
        if (nearest - tick_now > ticks)
          nearest = tick_now + ticks;
      end else begin
        running = 1'b1;
        nearest = tick_now + ticks;
      end
      asleep[t]   = 1'b1;
      deadline[t] = tick_now + ticks;
    endfunction

    // one tick: advance the counter, scan the tasks when the nearest deadline hits
    function bit [NUM_TASKS-1:0] advance_tick();
      bit [NUM_TASKS-1:0] woke;
      bit [TIME_W-1:0]    best;
      bit [TIME_W-1:0]    span;
      bit                 found;
      woke  = '0;
      best  = '0;
      found = 1'b0;
      if (!running)
        return woke;
      tick_now = tick_now + 1;
      if (nearest != tick_now)
        return woke;
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (asleep[t]) begin
          if (deadline[t] == tick_now) begin
            asleep[t] = 1'b0;
            woke[t]   = 1'b1;
          end else begin
            // wrapping distance, first task wins a tie
            span = deadline[t] - tick_now;
            if (!found || span < best) begin
              found   = 1'b1;
              best    = span;
              nearest = deadline[t];
            end
          end
        end
      end
      if (!found)
        running = 1'b0;
      return woke;
    endfunction

    function void note_command(opcode_t op, logic [TASK_W-1:0] tid,
                               logic [TIME_W-1:0] amount);
      timer_result_t   res;
      bit [63:0]       us_ticks;
      res = '0;
      case (op)
        OP_TICK: begin
          res.wake_mask = advance_tick();
        end
        OP_SLEEP_SEC: begin
          if (amount >= SEC_REQ_LIMIT)
            res.status = 1'b1;
          else
            arm_task(tid, amount * 32'd100);
        end
        OP_SLEEP_US: begin
          if (debug_check && amount >= DEBUG_US_LIMIT)
            res.status = 1'b1;
          else if (amount >= US_REQ_LIMIT)
            res.status = 1'b1;
          else begin
            // round up to whole 10 ms ticks
            us_ticks = ({32'd0, amount} + 64'd9999) / 64'd10000;
            arm_task(tid, us_ticks[TIME_W-1:0]);
          end
        end
        default: ;
      endcase
      res.counting = running;
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [NUM_TASKS-1:0] got_mask, logic got_status,
                      logic got_counting);
      timer_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, wake_mask %h", got_mask));
        return;
      end
      want = expected_q.pop_front();
      if (got_mask !== want.wake_mask)
        report($sformatf("wake_mask got %h want %h", got_mask, want.wake_mask));
      if (got_status !== want.status)
        report($sformatf("status got %b want %b", got_status, want.status));
      if (got_counting !== want.counting)
        report($sformatf("counting got %b want %b", got_counting, want.counting));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           opcode;
  logic [TASK_W-1:0]    task_id;
  logic [TIME_W-1:0]    sleep_amount;
  logic                 done;
  logic [NUM_TASKS-1:0] wake_mask;
  logic                 status;
  logic                 counting;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_data;

  sleep_timer_scoreboard sb = new();
  int stall_cycles;

  multi_task_sleep_timer_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .task_id      (task_id),
    .sleep_amount (sleep_amount),
    .done         (done),
    .wake_mask    (wake_mask),
    .status       (status),
    .counting     (counting),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // every result is taken in its one done cycle, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(wake_mask, status, counting);
  end

  // watchdog: reset whenever a command, a result or a config word moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // drive one command word from a falling edge and hold it until taken;
  // start stays high when the next word follows right away
  task send_word(input opcode_t op, input logic [TASK_W-1:0] tid,
                 input logic [TIME_W-1:0] amount);
    @(negedge clk);
    start        <= 1'b1;
    opcode       <= op;
    task_id      <= tid;
    sleep_amount <= amount;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    sb.note_command(op, tid, amount);
  endtask

  // gap of some cycles with start low
  task hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start        <= 1'b0;
      opcode       <= 2'($urandom_range(3));
      task_id      <= TASK_W'($urandom_range(15));
      sleep_amount <= $urandom;
      repeat (cycles - 1)
        @(negedge clk);
    end
  endtask

  // sender pauses until every expected result is back
  task drain();
    hold_off(1);
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  // config word is only written while the block is idle
  task write_debug_check(input bit value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    sb.set_debug_check(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
  endtask

  // one random command word, weighted towards ticks and short sleeps so
  // tasks actually wake; the rest covers limits, full-range values and noise
  task send_random_word();
    int               pick;
    logic [TASK_W-1:0] tid;
    tid  = TASK_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 55)
      send_word(OP_TICK, tid, $urandom);
    else if (pick < 75)
      send_word(OP_SLEEP_US, tid, $urandom_range(150000));
    else if (pick < 84)
      send_word(OP_SLEEP_SEC, tid, $urandom_range(2));
    else if (pick < 89)
      send_word(OP_SLEEP_US, tid, $urandom);
    else if (pick < 92)
      send_word(OP_SLEEP_SEC, tid, $urandom);
    else if (pick < 94)
      send_word(OP_SLEEP_SEC, tid, $urandom_range(SEC_REQ_LIMIT + 2, SEC_REQ_LIMIT - 2));
    else if (pick < 96)
      send_word(OP_SLEEP_US, tid,
                $urandom_range(DEBUG_US_LIMIT + 2, DEBUG_US_LIMIT - 2));
    else if (pick < 97)
      send_word(OP_SLEEP_US, tid,
                $urandom_range(US_REQ_LIMIT + 2, US_REQ_LIMIT - 2));
    else
      send_word(OP_NONE, tid, $urandom);
  endtask

  // random phase: bursts of words with random gaps, or no gaps at all
  task random_phase(input int words, input bit no_gaps);
    int left;
    int burst;
    left = words;
    while (left > 0) begin
      burst = $urandom_range(12, 1);
      if (burst > left)
        burst = left;
      repeat (burst)
        send_random_word();
      left -= burst;
      if (!no_gaps)
        hold_off(($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(5));
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_TICK;
    task_id      = '0;
    sleep_amount = '0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    repeat (3)
      @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_debug_check(1'b0);

    // directed: idle tick, zero duration, equal deadlines, wake all
    send_word(OP_TICK,      4'd0,  32'hFFFF_FFFF);
    send_word(OP_SLEEP_SEC, 4'd0,  32'd0);
    send_word(OP_SLEEP_US,  4'd1,  32'd10001);
    send_word(OP_SLEEP_US,  4'd2,  32'd0);
    send_word(OP_TICK,      4'd0,  32'd0);
    send_word(OP_TICK,      4'd0,  32'd0);
    // range limits on both units
    send_word(OP_SLEEP_SEC, 4'd15, SEC_REQ_LIMIT - 1);
    send_word(OP_SLEEP_SEC, 4'd3,  SEC_REQ_LIMIT);
    send_word(OP_SLEEP_US,  4'd4,  US_REQ_LIMIT - 1);
    send_word(OP_SLEEP_US,  4'd5,  US_REQ_LIMIT);
    send_word(OP_SLEEP_US,  4'd6,  32'hFFFF_FFFF);
    send_word(OP_SLEEP_SEC, 4'd7,  32'hFFFF_FFFF);
    send_word(OP_NONE,      4'd10, 32'hFFFF_FFFF);
    // overwrite of a sleeping task, nearest deadline pulled in
    send_word(OP_SLEEP_US,  4'd15, 32'd10000);
    send_word(OP_SLEEP_US,  4'd8,  32'd1);
    send_word(OP_SLEEP_SEC, 4'd9,  32'd1);
    send_word(OP_TICK,      4'd0,  32'd0);
    send_word(OP_SLEEP_US,  4'd9,  32'd20000);
    send_word(OP_TICK,      4'd0,  32'd0);
    send_word(OP_TICK,      4'd0,  32'd0);

    // debug check on: one second in microseconds is the first rejected value
    write_debug_check(1'b1);
    send_word(OP_SLEEP_US,  4'd11, DEBUG_US_LIMIT - 1);
    send_word(OP_SLEEP_US,  4'd12, DEBUG_US_LIMIT);
    send_word(OP_SLEEP_SEC, 4'd13, 32'd5);
    write_debug_check(1'b0);

    // random phases, debug check toggled between them, one phase with no gaps
    random_phase(205, 1'b0);
    write_debug_check(1'b1);
    random_phase(205, 1'b1);
    write_debug_check(1'b0);
    random_phase(205, 1'b0);
    write_debug_check(1'b1);
    random_phase(205, 1'b0);

    // let the last results come, then a few more cycles for stray strobes
    drain();
    repeat (NUM_TASKS + 4)
      @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
